>>> rtl/tlbpt_pkg.sv
// Shared types, constants and helpers for the TLB / page-table translation block.
// No dependencies; imported by the top level and the TLB cell.
package tlbpt_pkg;

  localparam int ADDR_W       = 16;
  localparam int FAULT_PAGE_W = 8;
  localparam int TOTAL_W      = 32;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [FAULT_PAGE_W-1:0] fault_page_t;
  typedef logic [TOTAL_W-1:0]      total_t;

  localparam total_t COUNT_MAX = '1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  // Hold at the top value instead of wrapping
  function automatic total_t sat_inc(input total_t v);
    return (v == COUNT_MAX) ? v : v + total_t'(1);
  endfunction

endpackage

>>> rtl/tlbpt_cell.sv
// One TLB slot: holds a tag, a frame and a valid bit, and passes the match
// result along the lookup chain. Depends on tlbpt_pkg.
module tlbpt_cell #(
  parameter int TAG_W   = 8,
  parameter int FRAME_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [TAG_W-1:0]   wr_tag,
  input  logic [FRAME_W-1:0] wr_frame,
  input  logic [TAG_W-1:0]   look_tag,
  input  logic               hit_in,
  input  logic [FRAME_W-1:0] frame_in,
  output logic               hit_out,
  output logic [FRAME_W-1:0] frame_out
);
  import tlbpt_pkg::*;

  logic               valid_r;
  logic [TAG_W-1:0]   tag_r;
  logic [FRAME_W-1:0] frame_r;
  logic               match;

  // Clear the valid bit on reset, set it on a refill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  // Load tag and frame on a refill
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_r   <= wr_tag;
      frame_r <= wr_frame;
    end
  end

  // Pass an earlier hit through; otherwise offer this slot's frame
  assign match     = valid_r && (tag_r == look_tag);
  assign hit_out   = hit_in || match;
  assign frame_out = (!hit_in && match) ? frame_r : frame_in;

endmodule

>>> rtl/tlbpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tlb_page_table_translation.sv
// Address translation top level: TLB cell row, page-table RAM and sequencer.
// Depends on tlbpt_pkg, tlbpt_cell and tlbpt_ram.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   in_logical_address
//   out_      output     out_valid / out_ready out_phys_addr, out_tlb_hit,
//                                              out_page_fault, out_fault_page,
//                                              out_hit_total, out_fault_total
//
// For each request the accept cycle issues the page-table read, then the
// lookup state searches the TLB row and resolves hit, table hit or fault.
// After reset the page table is swept clear, one entry a cycle, and in_ready
// stays low until the sweep ends.
// A result waits in the output register; a new request is taken meanwhile,
// and it completes once that register has been emptied.
module tlb_page_table_translation #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tlbpt_pkg::addr_t         in_logical_address,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tlbpt_pkg::addr_t         out_phys_addr,
  output logic                     out_tlb_hit,
  output logic                     out_page_fault,
  output tlbpt_pkg::fault_page_t   out_fault_page,
  output tlbpt_pkg::total_t        out_hit_total,
  output tlbpt_pkg::total_t        out_fault_total
);
  import tlbpt_pkg::*;

  localparam int PAGE_BITS  = $clog2(PAGE_COUNT);
  localparam int FRAME_BITS = $clog2(FRAME_COUNT);
  localparam int TLB_IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int VPN_W      = (OFFSET_BITS < ADDR_W) ? (ADDR_W - OFFSET_BITS) : 1;
  localparam int RED_W      = VPN_W + PAGE_BITS + 1;
  localparam int PA_EXT_W   = FRAME_BITS + OFFSET_BITS + ADDR_W;
  localparam int FP_EXT_W   = PAGE_BITS + FAULT_PAGE_W;

  state_t state_r, state_nxt;

  logic [PAGE_BITS-1:0]   clr_idx_r;
  logic [PAGE_BITS-1:0]   page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [FRAME_BITS-1:0]  free_frame_r;
  logic [TLB_IDX_W-1:0]   fifo_ptr_r;
  total_t                 hits_r;
  total_t                 faults_r;

  logic                   out_valid_r;
  addr_t                  out_pa_r;
  logic                   out_hit_r;
  logic                   out_fault_r;
  fault_page_t            out_fpage_r;

  logic                   accept;
  logic                   done;
  logic [ADDR_W+VPN_W-1:0] vpn_shift;
  logic [VPN_W-1:0]       vpn;
  logic [PAGE_BITS-1:0]   page_in;

  logic                   ram_we;
  logic [PAGE_BITS-1:0]   ram_waddr;
  logic [FRAME_BITS:0]    ram_wdata;
  logic [FRAME_BITS:0]    ram_rdata;
  logic                   map_valid;
  logic [FRAME_BITS-1:0]  map_frame;

  logic                   hit_chain   [TLB_ENTRIES+1];
  logic [FRAME_BITS-1:0]  frame_chain [TLB_ENTRIES+1];
  logic                   tlb_hit;
  logic [FRAME_BITS-1:0]  tlb_frame;
  logic                   fault;
  logic [FRAME_BITS-1:0]  frame;
  logic [PA_EXT_W-1:0]    pa_ext;
  logic [FP_EXT_W-1:0]    fp_ext;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Split off the page number
  assign vpn_shift = {{VPN_W{1'b0}}, in_logical_address} >> OFFSET_BITS;
  assign vpn       = vpn_shift[VPN_W-1:0];

  // Fold the page number into the table range
  generate
    if (PAGE_COUNT == (1 << PAGE_BITS)) begin : g_page_mask
      logic [VPN_W+PAGE_BITS-1:0] vpn_ext;
      assign vpn_ext = {{PAGE_BITS{1'b0}}, vpn};
      assign page_in = vpn_ext[PAGE_BITS-1:0];
    end else begin : g_page_reduce
      always_comb begin
        logic [RED_W-1:0] rem;
        rem = {{(PAGE_BITS+1){1'b0}}, vpn};
        for (int k = VPN_W - 1; k >= 0; k--) begin
          if (rem >= (RED_W'(PAGE_COUNT) << k)) begin
            rem = rem - (RED_W'(PAGE_COUNT) << k);
          end
        end
        page_in = rem[PAGE_BITS-1:0];
      end
    end
  endgenerate

  // Page table: valid bit above the frame number
  tlbpt_ram #(
    .WIDTH(FRAME_BITS + 1),
    .DEPTH(PAGE_COUNT)
  ) u_map_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (accept),
    .rd_addr(page_in),
    .rd_data(ram_rdata)
  );

  assign map_valid = ram_rdata[FRAME_BITS];
  assign map_frame = ram_rdata[FRAME_BITS-1:0];

  // Sweep clear after reset, then record new mappings on faults
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = page_r;
    ram_wdata = {1'b1, free_frame_r};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else if (done && fault) begin
      ram_we    = 1'b1;
    end
  end

  // TLB cell row; slot 0 leads so the lowest matching slot wins
  assign hit_chain[0]   = 1'b0;
  assign frame_chain[0] = '0;

  generate
    for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      logic cell_we;
      assign cell_we = done && fault && (fifo_ptr_r == TLB_IDX_W'(i));
      tlbpt_cell #(
        .TAG_W  (PAGE_BITS),
        .FRAME_W(FRAME_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cell_we),
        .wr_tag   (page_r),
        .wr_frame (free_frame_r),
        .look_tag (page_r),
        .hit_in   (hit_chain[i]),
        .frame_in (frame_chain[i]),
        .hit_out  (hit_chain[i+1]),
        .frame_out(frame_chain[i+1])
      );
    end
  endgenerate

  assign tlb_hit   = hit_chain[TLB_ENTRIES];
  assign tlb_frame = frame_chain[TLB_ENTRIES];

  // Resolve the translation
  assign fault = !tlb_hit && !map_valid;
  assign frame = tlb_hit ? tlb_frame : (map_valid ? map_frame : free_frame_r);
  assign done  = (state_r == ST_LOOK) && (!out_valid_r || out_ready);

  assign pa_ext = {{ADDR_W{1'b0}}, frame, offset_r};
  assign fp_ext = {{FAULT_PAGE_W{1'b0}}, page_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == PAGE_BITS'(PAGE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control state: sequencer, sweep index, allocators, counters, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      free_frame_r <= '0;
      fifo_ptr_r   <= '0;
      hits_r       <= '0;
      faults_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + PAGE_BITS'(1);
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (done && tlb_hit) begin
        hits_r <= sat_inc(hits_r);
      end
      if (done && fault) begin
        faults_r <= sat_inc(faults_r);
        free_frame_r <= (free_frame_r == FRAME_BITS'(FRAME_COUNT - 1)) ?
                        '0 : free_frame_r + FRAME_BITS'(1);
        fifo_ptr_r   <= (fifo_ptr_r == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                        '0 : fifo_ptr_r + TLB_IDX_W'(1);
      end
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r   <= page_in;
      offset_r <= in_logical_address[OFFSET_BITS-1:0];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (done) begin
      out_pa_r    <= pa_ext[ADDR_W-1:0];
      out_hit_r   <= tlb_hit;
      out_fault_r <= fault;
      out_fpage_r <= fault ? fp_ext[FAULT_PAGE_W-1:0] : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phys_addr        = out_pa_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_fault_r;
  assign out_fault_page       = out_fpage_r;
  assign out_hit_total        = hits_r;
  assign out_fault_total      = faults_r;

endmodule
